[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the reset is released.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("Assertion failed on the checked block.");

// Checked at every edge, also while the reset is held.
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("Assertion failed on the checked block.");

`endif

[rtl/hnu_pkg.sv]
package hnu_pkg;

    localparam int NEURONS = 6;
    localparam int CNT_W   = $clog2(NEURONS);
    localparam int DEPTH   = NEURONS * NEURONS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 3;
    localparam int VAL_W   = 16;
    localparam int VEC_W   = 6;
    localparam int EN_W    = 22;
    localparam int VIS_N   = (NEURONS < VEC_W) ? NEURONS : VEC_W;
    localparam int ACC_W   = $clog2((NEURONS * NEURONS + 2 * NEURONS) * 32768) + 2;

    localparam logic signed [ACC_W-1:0] E_MAX = ACC_W'(2097151);
    localparam logic signed [ACC_W-1:0] E_MIN = ACC_W'(-2097152);

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE_W = 2'd0,
        ACT_WRITE_T = 2'd1,
        ACT_SET_BIT = 2'd2,
        ACT_UPDATE  = 2'd3
    } t_action;

    typedef struct packed {
        logic load;
        logic wr_w1;
        logic wr_w2;
        logic wr_thr;
        logic set_bit;
        logic clr_acc;
        logic rst_cnt;
        logic upd_issue;
        logic en_issue;
        logic upd_apply;
        logic thr_add;
        logic out_fire;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    row_ok;
        logic    pair_ok;
        logic    j_last;
        logic    i_last;
    } t_dp_sts;

endpackage

[rtl/hopfield_neuron_update_top.sv]
// Channel   Handshake          Beat contents
// command   start, busy        i_action, i_row_index, i_col_index, i_fixed_value, i_bit_value
// result    o_valid (strobe)   o_neuron_bit, o_state_vector, o_energy
//
// A beat is taken when start is high and busy is low; busy falls as the result appears.
// Busy covers a sweep of all weight pairs and thresholds by one shared accumulator,
// preceded by a second write through the single weight RAM write port for a weight pair
// write and by one row sweep for an update. A new beat is taken only after the last result.
// Reset is synchronous and active low and clears states, weights and thresholds at once.
// The result strobe is high for one cycle and cannot be stalled.
module hopfield_neuron_update_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [hnu_pkg::ACT_W-1:0]        i_action,
    input  logic [hnu_pkg::IDX_W-1:0]        i_row_index,
    input  logic [hnu_pkg::IDX_W-1:0]        i_col_index,
    input  logic signed [hnu_pkg::VAL_W-1:0] i_fixed_value,
    input  logic                             i_bit_value,
    output logic                             o_valid,
    output logic                             o_neuron_bit,
    output logic [hnu_pkg::VEC_W-1:0]        o_state_vector,
    output logic signed [hnu_pkg::EN_W-1:0]  o_energy
);
    import hnu_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    hnu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hnu_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_fixed_value  (i_fixed_value),
        .i_bit_value    (i_bit_value),
        .o_valid        (o_valid),
        .o_neuron_bit   (o_neuron_bit),
        .o_state_vector (o_state_vector),
        .o_energy       (o_energy)
    );

endmodule

[rtl/hnu_ram.sv]
module hnu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/hnu_datapath.sv]
module hnu_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hnu_pkg::t_dp_cmd                    i_cmd,
    output hnu_pkg::t_dp_sts                    o_sts,
    input  logic [hnu_pkg::ACT_W-1:0]           i_action,
    input  logic [hnu_pkg::IDX_W-1:0]           i_row_index,
    input  logic [hnu_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [hnu_pkg::VAL_W-1:0]    i_fixed_value,
    input  logic                                i_bit_value,
    output logic                                o_valid,
    output logic                                o_neuron_bit,
    output logic [hnu_pkg::VEC_W-1:0]           o_state_vector,
    output logic signed [hnu_pkg::EN_W-1:0]     o_energy
);
    import hnu_pkg::*;

    t_action                   r_action;
    logic [IDX_W-1:0]          r_row;
    logic [IDX_W-1:0]          r_col;
    logic signed [VAL_W-1:0]   r_val;
    logic                      r_bit;
    logic [NEURONS-1:0]        r_states;
    logic signed [VAL_W-1:0]   r_thr [NEURONS];
    logic [DEPTH-1:0]          r_wvalid;
    logic [CNT_W-1:0]          r_i;
    logic [CNT_W-1:0]          r_j;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_pend;
    logic                      r_pend_use;
    logic                      r_pend_neg;
    logic                      r_rd_valid;

    logic [CNT_W-1:0]          row_ix;
    logic [CNT_W-1:0]          col_ix;
    logic [CNT_W-1:0]          thr_ix;
    logic                      row_ok;
    logic                      col_ok;
    logic [ADDR_W-1:0]         waddr;
    logic [ADDR_W-1:0]         raddr;
    logic                      we;
    logic                      mask;
    logic [VAL_W-1:0]          rdata;
    logic signed [VAL_W-1:0]   thr_rd;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W-1:0]   thr_term;
    logic signed [ACC_W-1:0]   sat;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return ADDR_W'(ADDR_W'(a) * ADDR_W'(NEURONS) + ADDR_W'(b));
    endfunction

    assign row_ix = CNT_W'(r_row);
    assign col_ix = CNT_W'(r_col);
    assign row_ok = int'(r_row) < NEURONS;
    assign col_ok = int'(r_col) < NEURONS;

    assign o_sts.action  = r_action;
    assign o_sts.row_ok  = row_ok;
    assign o_sts.pair_ok = row_ok && col_ok && (r_row != r_col);
    assign o_sts.j_last  = int'(r_j) == NEURONS - 1;
    assign o_sts.i_last  = int'(r_i) == NEURONS - 1;

    assign we    = i_cmd.wr_w1 | i_cmd.wr_w2;
    assign waddr = i_cmd.wr_w2 ? f_addr(col_ix, row_ix) : f_addr(row_ix, col_ix);
    assign raddr = i_cmd.upd_issue ? f_addr(row_ix, r_j) : f_addr(r_i, r_j);
    assign mask  = i_cmd.upd_issue ? r_states[r_j] : (r_states[r_i] & r_states[r_j]);

    assign thr_ix   = i_cmd.upd_apply ? row_ix : r_i;
    assign thr_rd   = r_thr[thr_ix];
    assign w_term   = r_rd_valid ? ACC_W'(signed'(rdata)) : '0;
    assign thr_term = ACC_W'(thr_rd) <<< 1;

    always_comb begin
        if (r_acc > E_MAX) begin
            sat = E_MAX;
        end else if (r_acc < E_MIN) begin
            sat = E_MIN;
        end else begin
            sat = r_acc;
        end
    end

    hnu_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states   <= '0;
            r_wvalid   <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_acc      <= '0;
            r_pend     <= 1'b0;
            r_pend_use <= 1'b0;
            r_pend_neg <= 1'b0;
            r_rd_valid <= 1'b0;
            o_valid    <= 1'b0;
            for (int k = 0; k < NEURONS; k++) begin
                r_thr[k] <= '0;
            end
        end else begin
            o_valid    <= i_cmd.out_fire;
            r_pend     <= i_cmd.upd_issue | i_cmd.en_issue;
            r_pend_use <= mask;
            r_pend_neg <= i_cmd.en_issue;
            r_rd_valid <= r_wvalid[raddr];

            if (we) begin
                r_wvalid[waddr] <= 1'b1;
            end
            if (i_cmd.wr_thr) begin
                r_thr[row_ix] <= r_val;
            end
            if (i_cmd.set_bit) begin
                r_states[row_ix] <= r_bit;
            end
            if (i_cmd.upd_apply) begin
                r_states[row_ix] <= !(r_acc < ACC_W'(thr_rd));
            end

            if (i_cmd.clr_acc) begin
                r_acc <= '0;
            end else if (r_pend && r_pend_use) begin
                r_acc <= r_pend_neg ? (r_acc - w_term) : (r_acc + w_term);
            end else if (i_cmd.thr_add && r_states[r_i]) begin
                r_acc <= r_acc + thr_term;
            end

            if (i_cmd.rst_cnt) begin
                r_i <= '0;
                r_j <= '0;
            end else if (i_cmd.upd_issue) begin
                r_j <= r_j + 1'b1;
            end else if (i_cmd.en_issue) begin
                if (o_sts.j_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else if (i_cmd.thr_add) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_row    <= i_row_index;
            r_col    <= i_col_index;
            r_val    <= i_fixed_value;
            r_bit    <= i_bit_value;
        end
        if (i_cmd.out_fire) begin
            o_neuron_bit   <= row_ok ? r_states[row_ix] : 1'b0;
            o_state_vector <= VEC_W'(r_states[VIS_N-1:0]);
            o_energy       <= EN_W'(sat);
        end
    end

endmodule

[rtl/hnu_ctrl.sv]
module hnu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  hnu_pkg::t_dp_sts i_sts,
    output hnu_pkg::t_dp_cmd o_cmd
);
    import hnu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WR2,
        S_UPD,
        S_UPD_DRAIN,
        S_UPD_APPLY,
        S_EN,
        S_EN_DRAIN,
        S_THR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    assign o_busy = r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_busy     = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.clr_acc = 1'b1;
                o_cmd.rst_cnt = 1'b1;
                n_state       = S_EN;
                if (i_sts.row_ok) begin
                    case (i_sts.action)
                        ACT_WRITE_W: begin
                            if (i_sts.pair_ok) begin
                                o_cmd.wr_w1 = 1'b1;
                                n_state     = S_WR2;
                            end
                        end
                        ACT_WRITE_T: o_cmd.wr_thr  = 1'b1;
                        ACT_SET_BIT: o_cmd.set_bit = 1'b1;
                        ACT_UPDATE:  n_state       = S_UPD;
                        default:     n_state       = S_EN;
                    endcase
                end
            end
            S_WR2: begin
                o_cmd.wr_w2 = 1'b1;
                n_state     = S_EN;
            end
            S_UPD: begin
                o_cmd.upd_issue = 1'b1;
                if (i_sts.j_last) begin
                    n_state = S_UPD_DRAIN;
                end
            end
            S_UPD_DRAIN: begin
                n_state = S_UPD_APPLY;
            end
            S_UPD_APPLY: begin
                o_cmd.upd_apply = 1'b1;
                o_cmd.clr_acc   = 1'b1;
                o_cmd.rst_cnt   = 1'b1;
                n_state         = S_EN;
            end
            S_EN: begin
                o_cmd.en_issue = 1'b1;
                if (i_sts.i_last && i_sts.j_last) begin
                    n_state = S_EN_DRAIN;
                end
            end
            S_EN_DRAIN: begin
                o_cmd.rst_cnt = 1'b1;
                n_state       = S_THR;
            end
            S_THR: begin
                o_cmd.thr_add = 1'b1;
                if (i_sts.i_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_fire = 1'b1;
                n_busy         = 1'b0;
                n_state        = S_IDLE;
            end
            default: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

endmodule

[rtl/hnu_checker.sv]
`include "assert_macros.svh"

module hnu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    `ASSERT_CLK(a_take_sets_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_CLK(a_result_when_free, i_clk, i_rst_n, o_valid |-> !busy)
    `ASSERT_CLK(a_single_strobe, i_clk, i_rst_n, o_valid |=> !o_valid)
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, (!i_rst_n) |=> (!o_valid && !busy))

endmodule

bind hopfield_neuron_update_top hnu_checker u_hnu_checker (.*);
